// ===== hdl/gamepad_slot_table_merger_macros.svh =====
// ----------------------------------------------------------------------------
// Gamepad slot table merger assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SLOT_TABLE_MERGER_MACROS_SVH
`define GAMEPAD_SLOT_TABLE_MERGER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GSTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define GSTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GSTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GSTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/gstm_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad slot table merger package
// Table sizes, derived widths and the merge accumulator result type.
// ----------------------------------------------------------------------------
package gstm_pkg;

    localparam int MAX_PADS = 8;
    localparam int NUM_AXES = 6;

    localparam int SLOT_W   = (MAX_PADS > 1) ? $clog2(MAX_PADS) : 1;
    localparam int COUNT_W  = $clog2(MAX_PADS + 1);
    localparam int AX_DEPTH = MAX_PADS * NUM_AXES;
    localparam int AX_AW    = (AX_DEPTH > 1) ? $clog2(AX_DEPTH) : 1;
    localparam int AX_CW    = $clog2(AX_DEPTH + 1);

    localparam int DEV_W = 8;
    localparam int BTN_W = 32;
    localparam int AXV_W = 16;

    // Running merge over the pads visited by a query scan.
    typedef struct packed {
        logic [BTN_W-1:0]        ored;
        logic signed [AXV_W-1:0] best;
        logic                    same;
        logic                    any_sel;
        logic                    any_st;
    } t_acc;

endpackage

// ===== hdl/gstm_merge_acc.sv =====
// ----------------------------------------------------------------------------
// Gamepad slot table merge accumulator
// Folds one pad per cycle, while i_valid is high, into the button OR, chord flags and axis maximum.
// ----------------------------------------------------------------------------
module gstm_merge_acc
    import gstm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_start,
    input  logic                    i_valid,
    input  logic [BTN_W-1:0]        i_buttons,
    input  logic signed [AXV_W-1:0] i_axis_value,
    input  logic                    i_axis_ok,
    input  logic [BTN_W-1:0]        i_sel_mask,
    input  logic [BTN_W-1:0]        i_st_mask,
    output t_acc                    o_acc
);

    logic [BTN_W-1:0]        r_ored;
    logic signed [AXV_W-1:0] r_best;
    logic [AXV_W:0]          r_mag;
    logic                    r_same;
    logic                    r_any_sel;
    logic                    r_any_st;

    logic [AXV_W:0] ext;
    logic [AXV_W:0] mag;
    logic           sel;
    logic           st;

    // The magnitude is one bit wider so that the most negative value maps to 2^15.
    assign ext = {i_axis_value[AXV_W-1], i_axis_value};
    assign mag = ext[AXV_W] ? (~ext + {{AXV_W{1'b0}}, 1'b1}) : ext;
    assign sel = (i_buttons & i_sel_mask) != '0;
    assign st  = (i_buttons & i_st_mask) != '0;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ored    <= '0;
            r_best    <= '0;
            r_mag     <= '0;
            r_same    <= 1'b0;
            r_any_sel <= 1'b0;
            r_any_st  <= 1'b0;
        end else if (i_valid) begin
            r_ored <= r_ored | i_buttons;
            if (sel && st) begin
                r_same <= 1'b1;
            end
            if (sel) begin
                r_any_sel <= 1'b1;
            end
            if (st) begin
                r_any_st <= 1'b1;
            end
            // Strictly greater, so an earlier pad keeps a tie.
            if (i_axis_ok && (mag > r_mag)) begin
                r_mag  <= mag;
                r_best <= i_axis_value;
            end
        end
    end

    assign o_acc.ored    = r_ored;
    assign o_acc.best    = r_best;
    assign o_acc.same    = r_same;
    assign o_acc.any_sel = r_any_sel;
    assign o_acc.any_st  = r_any_st;

endmodule

// ===== hdl/gamepad_slot_table_merger.sv =====
// ----------------------------------------------------------------------------
// Gamepad slot table merger
// Compacted table of connected pads with button and axis merging.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tuser: func; tdata: device_id, control_bits, pressed,
//                      axis_index, axis_value
// m_axis    out        tdata: status, slot, merged_controls, merged_axis,
//                      chord, log_now, denial_count
// i_cfg     in         register index, 32-bit write data, write enable
//
// One word is in flight at a time. After acceptance, a scan reads one slot
// per cycle from the device/button memories; a query visits every pad, and
// a lookup stops past the matching slot or runs over every pad when the pad
// is missing. Admitting a new pad or a snapshot adds a sweep that zeroes the
// pad's NUM_AXES axes; a remove compacts the table by copying every later
// pad's axis, device and button entries down one slot. The done state hands
// the result to the output register once that register is free, and the
// input is ready again after that. Unused func codes go straight to the done
// state, skipping the scan.
// Reset clears the pad count, the chord latch, the denial count and the
// configuration masks. The memories are not cleared: every entry below the
// pad count has been written by an admit before it is read.
// The result waits in its own output register, so a new word is accepted
// while the previous result is still stalled on m_axis_tready.
//
`include "gamepad_slot_table_merger_macros.svh"

module gamepad_slot_table_merger
    import gstm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // device_id[7:0], control_bits[39:8],
                                        // pressed[40], axis_index[43:41],
                                        // axis_value[59:44], zero fill
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status[0], slot[3:1],
                                        // merged_controls[35:4],
                                        // merged_axis[51:36], chord[53:52],
                                        // log_now[54], denial_count[70:55],
                                        // zero fill
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        F_ADMIT  = 3'd0,
        F_REMOVE = 3'd1,
        F_SNAP   = 3'd2,
        F_SETC   = 3'd3,
        F_SETAX  = 3'd4,
        F_QUERY  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        CHORD_NONE  = 2'd0,
        CHORD_SAME  = 2'd1,
        CHORD_CROSS = 2'd2
    } t_chord;

    localparam logic CFG_SELECT = 1'b0;
    localparam logic CFG_START  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CLEAR,
        S_COPY,
        S_DONE
    } t_state;

    // Control state.
    t_state           r_state;
    logic [COUNT_W-1:0] r_pad_count;
    logic             r_latch;
    logic [15:0]      r_denials;
    logic             r_out_valid;
    logic             r_pend;
    logic [BTN_W-1:0] r_sel_mask;
    logic [BTN_W-1:0] r_st_mask;

    // Latched input word.
    logic [2:0]              r_func;
    logic [DEV_W-1:0]        r_dev;
    logic [BTN_W-1:0]        r_bits;
    logic                    r_pressed;
    logic [2:0]              r_axis;
    logic signed [AXV_W-1:0] r_value;

    // Scan and sweep bookkeeping.
    logic [COUNT_W-1:0] r_scan;
    logic [AX_CW-1:0]   r_scan_base;
    logic [SLOT_W-1:0]  r_pend_slot;
    logic [AX_CW-1:0]   r_pend_base;
    logic               r_pend_k0;
    logic [SLOT_W-1:0]  r_ent;
    logic [2:0]         r_k;
    logic [AX_CW-1:0]   r_sw_addr;
    logic [AX_CW-1:0]   r_sw_end;

    // Result being built, and the output register.
    logic              r_res_status;
    logic [2:0]        r_res_slot;
    logic [BTN_W-1:0]  r_res_merged;
    logic [AXV_W-1:0]  r_res_axis;
    logic [1:0]        r_res_chord;
    logic              r_res_log;
    logic [15:0]       r_res_dcount;
    logic              r_out_status;
    logic [2:0]        r_out_slot;
    logic [BTN_W-1:0]  r_out_merged;
    logic [AXV_W-1:0]  r_out_axis;
    logic [1:0]        r_out_chord;
    logic              r_out_log;
    logic [15:0]       r_out_dcount;

    // Memories and their registered read data.
    logic [DEV_W-1:0] mem_dev [MAX_PADS];
    logic [BTN_W-1:0] mem_btn [MAX_PADS];
    logic [AXV_W-1:0] mem_ax  [AX_DEPTH];
    logic [DEV_W-1:0] r_dev_rd;
    logic [BTN_W-1:0] r_btn_rd;
    logic [AXV_W-1:0] r_ax_rd;

    logic [SLOT_W-1:0] ent_raddr;
    logic [AX_AW-1:0]  ax_raddr;
    logic              dev_we;
    logic [SLOT_W-1:0] dev_waddr;
    logic [DEV_W-1:0]  dev_wdata;
    logic              btn_we;
    logic [SLOT_W-1:0] btn_waddr;
    logic [BTN_W-1:0]  btn_wdata;
    logic              ax_we;
    logic [AX_AW-1:0]  ax_waddr;
    logic [AXV_W-1:0]  ax_wdata;

    logic              in_accept;
    logic              axis_ok;
    logic [2:0]        axis_sel;
    logic [AX_CW-1:0]  scan_ax_sum;
    logic [AX_CW-1:0]  copy_src;
    logic              scan_more;
    logic              dev_match;
    logic              table_full;
    logic              copy_more;
    logic              acc_valid;
    t_acc              acc;
    logic              q_inc;
    logic [15:0]       n_denials;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign axis_ok       = ({1'b0, r_axis} < 4'(NUM_AXES));
    assign axis_sel      = axis_ok ? r_axis : 3'd0;
    assign scan_ax_sum   = r_scan_base + AX_CW'(axis_sel);
    assign copy_src      = r_sw_addr + AX_CW'(NUM_AXES);
    assign scan_more     = (r_scan < r_pad_count);
    assign dev_match     = r_pend && (r_dev_rd == r_dev);
    assign table_full    = (r_pad_count == COUNT_W'(MAX_PADS));
    assign copy_more     = ((COUNT_W'(r_ent) + COUNT_W'(1)) < r_pad_count);
    assign acc_valid     = (r_state == S_SCAN) && (r_func == F_QUERY) && r_pend;

    // A cross-pad chord counts only on the first query of its episode.
    assign q_inc     = !acc.same && acc.any_sel && acc.any_st && !r_latch;
    assign n_denials = (q_inc && (r_denials != 16'hFFFF)) ? (r_denials + 16'd1) : r_denials;

    gstm_merge_acc u_acc (
        .i_clk        (i_clk),
        .i_start      (in_accept),
        .i_valid      (acc_valid),
        .i_buttons    (r_btn_rd),
        .i_axis_value (r_ax_rd),
        .i_axis_ok    (axis_ok),
        .i_sel_mask   (r_sel_mask),
        .i_st_mask    (r_st_mask),
        .o_acc        (acc)
    );

    // Memory addresses and write strobes follow the state. Reads happen every
    // cycle; the read data is registered and used in the cycle after its address was presented.
    always_comb begin
        ent_raddr = r_scan[SLOT_W-1:0];
        ax_raddr  = scan_ax_sum[AX_AW-1:0];
        dev_we    = 1'b0;
        dev_waddr = r_pend_slot;
        dev_wdata = r_dev;
        btn_we    = 1'b0;
        btn_waddr = r_pend_slot;
        btn_wdata = r_bits;
        ax_we     = 1'b0;
        ax_waddr  = r_sw_addr[AX_AW-1:0];
        ax_wdata  = '0;
        case (r_state)
            S_SCAN: begin
                if ((r_func != F_QUERY) && dev_match) begin
                    case (r_func)
                        F_SNAP: begin
                            btn_we = 1'b1;
                        end
                        F_SETC: begin
                            btn_we    = 1'b1;
                            btn_wdata = r_pressed ? (r_btn_rd | r_bits) : (r_btn_rd & ~r_bits);
                        end
                        F_SETAX: begin
                            // The pending base plus the axis gives the entry.
                            ax_we    = axis_ok;
                            ax_waddr = AX_AW'(r_pend_base + AX_CW'(axis_sel));
                            ax_wdata = r_value;
                        end
                        default: begin
                        end
                    endcase
                end else if ((r_func == F_ADMIT) && !scan_more && !r_pend && !table_full) begin
                    // Append: device id in, buttons zero; axes zeroed by the sweep.
                    dev_we    = 1'b1;
                    dev_waddr = r_pad_count[SLOT_W-1:0];
                    btn_we    = 1'b1;
                    btn_waddr = r_pad_count[SLOT_W-1:0];
                    btn_wdata = '0;
                end
            end
            S_CLEAR: begin
                ax_we = 1'b1;
            end
            S_COPY: begin
                // Read one entry ahead, write the word read in the last cycle.
                ent_raddr = r_ent + SLOT_W'(1);
                ax_raddr  = copy_src[AX_AW-1:0];
                ax_we     = r_pend;
                ax_waddr  = r_pend_base[AX_AW-1:0];
                ax_wdata  = r_ax_rd;
                dev_we    = r_pend && r_pend_k0;
                dev_wdata = r_dev_rd;
                btn_we    = r_pend && r_pend_k0;
                btn_wdata = r_btn_rd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dev_we) begin
            mem_dev[dev_waddr] <= dev_wdata;
        end
        if (btn_we) begin
            mem_btn[btn_waddr] <= btn_wdata;
        end
        if (ax_we) begin
            mem_ax[ax_waddr] <= ax_wdata;
        end
        r_dev_rd <= mem_dev[ent_raddr];
        r_btn_rd <= mem_btn[ent_raddr];
        r_ax_rd  <= mem_ax[ax_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pad_count <= '0;
            r_latch     <= 1'b0;
            r_denials   <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_sel_mask  <= '0;
            r_st_mask   <= '0;
        end else begin
            // The user must write configuration only while idle; the block does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SELECT: r_sel_mask <= i_cfg_wdata;
                    CFG_START:  r_st_mask  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // In the done state the output register is updated below instead.
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_func       <= s_axis_tuser;
                        r_dev        <= s_axis_tdata[7:0];
                        r_bits       <= s_axis_tdata[39:8];
                        r_pressed    <= s_axis_tdata[40];
                        r_axis       <= s_axis_tdata[43:41];
                        r_value      <= s_axis_tdata[59:44];
                        r_scan       <= '0;
                        r_scan_base  <= '0;
                        r_pend       <= 1'b0;
                        r_res_status <= 1'b1;
                        r_res_slot   <= '0;
                        r_res_merged <= '0;
                        r_res_axis   <= '0;
                        r_res_chord  <= CHORD_NONE;
                        r_res_log    <= 1'b0;
                        r_res_dcount <= '0;
                        // Unused func codes fail without touching the table.
                        if (s_axis_tuser > F_QUERY) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (r_func == F_QUERY) begin
                        r_pend      <= scan_more;
                        r_pend_slot <= r_scan[SLOT_W-1:0];
                        r_pend_base <= r_scan_base;
                        if (scan_more) begin
                            r_scan      <= r_scan + COUNT_W'(1);
                            r_scan_base <= r_scan_base + AX_CW'(NUM_AXES);
                        end else if (!r_pend) begin
                            // All pads folded in: classify the chord.
                            r_res_status <= 1'b0;
                            r_res_merged <= acc.ored;
                            r_res_axis   <= acc.best;
                            r_res_dcount <= n_denials;
                            r_denials    <= n_denials;
                            if (acc.same) begin
                                r_res_chord <= CHORD_SAME;
                            end else if (acc.any_sel && acc.any_st) begin
                                r_res_chord <= CHORD_CROSS;
                                r_res_log   <= !r_latch;
                                r_latch     <= 1'b1;
                            end else begin
                                r_latch <= 1'b0;
                            end
                            r_state <= S_DONE;
                        end
                    end else if (dev_match) begin
                        r_pend <= 1'b0;
                        case (r_func)
                            F_ADMIT: begin
                                r_res_status <= 1'b0;
                                r_res_slot   <= 3'(r_pend_slot);
                                r_state      <= S_DONE;
                            end
                            F_REMOVE: begin
                                r_res_status <= 1'b0;
                                r_ent        <= r_pend_slot;
                                r_k          <= '0;
                                r_sw_addr    <= r_pend_base;
                                r_state      <= S_COPY;
                            end
                            F_SNAP: begin
                                r_res_status <= 1'b0;
                                r_sw_addr    <= r_pend_base;
                                r_sw_end     <= r_pend_base + AX_CW'(NUM_AXES);
                                r_state      <= S_CLEAR;
                            end
                            F_SETC: begin
                                r_res_status <= 1'b0;
                                r_state      <= S_DONE;
                            end
                            F_SETAX: begin
                                r_res_status <= !axis_ok;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else if (!scan_more && !r_pend) begin
                        // Pad not in the table.
                        if ((r_func == F_ADMIT) && !table_full) begin
                            r_res_status <= 1'b0;
                            r_res_slot   <= 3'(r_pad_count);
                            r_pad_count  <= r_pad_count + COUNT_W'(1);
                            r_sw_addr    <= r_scan_base;
                            r_sw_end     <= r_scan_base + AX_CW'(NUM_AXES);
                            r_state      <= S_CLEAR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_pend      <= scan_more;
                        r_pend_slot <= r_scan[SLOT_W-1:0];
                        r_pend_base <= r_scan_base;
                        if (scan_more) begin
                            r_scan      <= r_scan + COUNT_W'(1);
                            r_scan_base <= r_scan_base + AX_CW'(NUM_AXES);
                        end
                    end
                end

                S_CLEAR: begin
                    r_sw_addr <= r_sw_addr + AX_CW'(1);
                    if ((r_sw_addr + AX_CW'(1)) == r_sw_end) begin
                        r_state <= S_DONE;
                    end
                end

                S_COPY: begin
                    if (copy_more) begin
                        r_pend      <= 1'b1;
                        r_pend_slot <= r_ent;
                        r_pend_base <= r_sw_addr;
                        r_pend_k0   <= (r_k == 3'd0);
                        r_sw_addr   <= r_sw_addr + AX_CW'(1);
                        if (r_k == 3'(NUM_AXES - 1)) begin
                            r_k   <= '0;
                            r_ent <= r_ent + SLOT_W'(1);
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_pad_count <= r_pad_count - COUNT_W'(1);
                            r_state     <= S_DONE;
                        end
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_slot   <= r_res_slot;
                        r_out_merged <= r_res_merged;
                        r_out_axis   <= r_res_axis;
                        r_out_chord  <= r_res_chord;
                        r_out_log    <= r_res_log;
                        r_out_dcount <= r_res_dcount;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_dcount, r_out_log, r_out_chord, r_out_axis,
                            r_out_merged, r_out_slot, r_out_status};

    `GSTM_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_pad_count <= COUNT_W'(MAX_PADS), "pad count above table size")
    `GSTM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_accept, r_state != S_IDLE, "accepted word did not start work")
    `GSTM_ASSERT_IMP(a_log_cross, i_clk, i_rst_n, r_out_valid && r_out_log, r_out_chord == CHORD_CROSS, "log raised without cross-pad chord")
    `GSTM_ASSERT_IMP(a_ax_addr, i_clk, i_rst_n, ax_we, {1'b0, ax_waddr} < (AX_AW + 1)'(AX_DEPTH), "axis write beyond memory")

endmodule
